// ===== rtl/ttc_pkg.sv =====
package ttc_pkg;

    // Character codes with a control meaning
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_SPACE = 8'd32;

    // Cell geometry and pixel offsets
    localparam logic [12:0] CELL_W    = 13'd6;
    localparam logic [12:0] CELL_H    = 13'd8;
    localparam logic [9:0]  PIX_OFF_X = 10'd2;
    localparam logic [9:0]  PIX_OFF_Y = 10'd11;

    // Register map: index is paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_WINDOW_X   = 3'd0;
    localparam logic [2:0] REG_WINDOW_Y   = 3'd1;
    localparam logic [2:0] REG_GLYPH_SCALE = 3'd2;
    localparam logic [2:0] REG_COLUMNS    = 3'd3;
    localparam logic [2:0] REG_ROWS       = 3'd4;
    localparam logic [2:0] REG_INK_COLOUR = 3'd5;
    localparam logic [2:0] REG_ALT_ERASE  = 3'd6;

    // Register reset values
    localparam logic [9:0] RST_WINDOW_X    = 10'd0;
    localparam logic [9:0] RST_WINDOW_Y    = 10'd0;
    localparam logic [3:0] RST_GLYPH_SCALE = 4'd1;
    localparam logic [5:0] RST_COLUMNS     = 6'd52;
    localparam logic [5:0] RST_ROWS        = 6'd28;
    localparam logic [3:0] RST_INK_COLOUR  = 4'd15;
    localparam logic [7:0] RST_ALT_ERASE   = 8'd127;

    typedef struct packed {
        logic [9:0] window_x;
        logic [9:0] window_y;
        logic [3:0] glyph_scale;
        logic [5:0] columns;
        logic [5:0] rows;
        logic [3:0] ink_colour;
        logic [7:0] alt_erase_code;
    } cfg_t;

    typedef struct packed {
        logic       draw_valid;
        logic [7:0] draw_glyph;
        logic [9:0] draw_x;
        logic [9:0] draw_y;
        logic [3:0] draw_colour;
        logic       scroll_request;
        logic [5:0] cursor_col;
        logic [5:0] cursor_row;
    } res_t;

endpackage

// ===== rtl/ttc_cfg.sv =====
module ttc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output ttc_pkg::cfg_t              cfg
);
    import ttc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write registers on the access beat; drop writes beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_x       <= RST_WINDOW_X;
            cfg_reg.window_y       <= RST_WINDOW_Y;
            cfg_reg.glyph_scale    <= RST_GLYPH_SCALE;
            cfg_reg.columns        <= RST_COLUMNS;
            cfg_reg.rows           <= RST_ROWS;
            cfg_reg.ink_colour     <= RST_INK_COLOUR;
            cfg_reg.alt_erase_code <= RST_ALT_ERASE;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WINDOW_X:    cfg_reg.window_x       <= pwdata[9:0];
                REG_WINDOW_Y:    cfg_reg.window_y       <= pwdata[9:0];
                REG_GLYPH_SCALE: cfg_reg.glyph_scale    <= pwdata[3:0];
                REG_COLUMNS:     cfg_reg.columns        <= pwdata[5:0];
                REG_ROWS:        cfg_reg.rows           <= pwdata[5:0];
                REG_INK_COLOUR:  cfg_reg.ink_colour     <= pwdata[3:0];
                REG_ALT_ERASE:   cfg_reg.alt_erase_code <= pwdata[7:0];
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_WINDOW_X:    prdata = {22'd0, cfg_reg.window_x};
            REG_WINDOW_Y:    prdata = {22'd0, cfg_reg.window_y};
            REG_GLYPH_SCALE: prdata = {28'd0, cfg_reg.glyph_scale};
            REG_COLUMNS:     prdata = {26'd0, cfg_reg.columns};
            REG_ROWS:        prdata = {26'd0, cfg_reg.rows};
            REG_INK_COLOUR:  prdata = {28'd0, cfg_reg.ink_colour};
            REG_ALT_ERASE:   prdata = {24'd0, cfg_reg.alt_erase_code};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/ttc_step.sv =====
module ttc_step (
    input  logic [7:0]    char_code,
    input  logic [5:0]    col,
    input  logic [5:0]    row,
    input  ttc_pkg::cfg_t cfg,
    output ttc_pkg::res_t res
);
    import ttc_pkg::*;

    logic [5:0]  ncol;
    logic [5:0]  nrow;
    logic [6:0]  col_w;
    logic [6:0]  row_w;
    logic [5:0]  pcol;
    logic [5:0]  prow;
    logic        draw;
    logic        scroll;
    logic        is_erase;
    logic [7:0]  glyph;
    logic [12:0] mx;
    logic [12:0] my;

    // Decode the character and move the cursor
    always_comb
    begin
        ncol     = (cfg.columns == 6'd0) ? 6'd1 : cfg.columns;
        nrow     = (cfg.rows == 6'd0) ? 6'd1 : cfg.rows;
        col_w    = {1'b0, col};
        row_w    = {1'b0, row};
        pcol     = col;
        prow     = row;
        draw     = 1'b0;
        scroll   = 1'b0;
        glyph    = 8'd0;
        is_erase = (char_code == CODE_BS) || (char_code == cfg.alt_erase_code);

        priority if (char_code == CODE_NL)
        begin
            col_w = 7'd0;
            row_w = row_w + 7'd1;
        end
        else if (char_code == CODE_CR)
        begin
            col_w = 7'd0;
        end
        else if (is_erase)
        begin
            // Step back one cell unless at home, and blank it
            if ((row != 6'd0) || (col != 6'd0))
            begin
                if (col != 6'd0)
                begin
                    col_w = col_w - 7'd1;
                end
                else
                begin
                    col_w = {1'b0, ncol} - 7'd1;
                    row_w = row_w - 7'd1;
                end
                draw  = 1'b1;
                glyph = CODE_SPACE;
                pcol  = col_w[5:0];
                prow  = row_w[5:0];
            end
        end
        else
        begin
            draw  = 1'b1;
            glyph = char_code;
            col_w = col_w + 7'd1;
        end

        // Wrap a full line
        if (col_w >= {1'b0, ncol})
        begin
            row_w = row_w + 7'd1;
            col_w = 7'd0;
        end

        // Scroll past the last row and pin the cursor
        if (row_w >= {1'b0, nrow})
        begin
            scroll = 1'b1;
            row_w  = {1'b0, nrow} - 7'd1;
            col_w  = 7'd0;
        end
    end

    // Pixel position of the drawn cell, modulo 1024
    assign mx = 13'(cfg.glyph_scale) * 13'(pcol) * CELL_W;
    assign my = 13'(cfg.glyph_scale) * 13'(prow) * CELL_H;

    always_comb
    begin
        res.draw_valid     = draw;
        res.draw_glyph     = draw ? glyph : 8'd0;
        res.draw_x         = draw ? (cfg.window_x + mx[9:0] + PIX_OFF_X) : 10'd0;
        res.draw_y         = draw ? (cfg.window_y + my[9:0] + PIX_OFF_Y) : 10'd0;
        res.draw_colour    = draw ? cfg.ink_colour : 4'd0;
        res.scroll_request = scroll;
        res.cursor_col     = col_w[5:0];
        res.cursor_row     = row_w[5:0];
    end

endmodule

// ===== rtl/text_terminal_cursor_top.sv =====
// Text terminal cursor: takes one character per beat on the input channel and
// returns one beat per character with the cursor after it, an optional glyph
// draw request (a space for backspace) at the cell's pixel position and a
// scroll request when the cursor runs past the last row. A character goes
// through an input register and the cursor logic into the result register,
// from which the result is offered. The block takes one character per cycle
// while the input is not stalled: the cursor column and row are updated in
// the same cycle as the result is registered, so the next character sees them
// at once. The input stalls only when both the input and result registers are
// full and the output is stalled. Configure through the APB port while no
// character is in flight.
module text_terminal_cursor_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 char_code,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       draw_valid,
    output logic [7:0]                 draw_glyph,
    output logic [9:0]                 draw_x,
    output logic [9:0]                 draw_y,
    output logic [3:0]                 draw_colour,
    output logic                       scroll_request,
    output logic [5:0]                 cursor_col,
    output logic [5:0]                 cursor_row
);
    import ttc_pkg::*;

    cfg_t       cfg;
    res_t       res_next;
    res_t       res_reg;
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       out_valid_reg;
    logic [5:0] col_reg;
    logic [5:0] row_reg;
    logic       out_load;
    logic       in_take;

    ttc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttc_step u_step (
        .char_code (char_reg),
        .col       (col_reg),
        .row       (row_reg),
        .cfg       (cfg),
        .res       (res_next)
    );

    // Pipeline advance
    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // Hold control state: stage valids and the cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= 6'd0;
            row_reg       <= 6'd0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                col_reg       <= res_next.cursor_col;
                row_reg       <= res_next.cursor_row;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign draw_valid     = res_reg.draw_valid;
    assign draw_glyph     = res_reg.draw_glyph;
    assign draw_x         = res_reg.draw_x;
    assign draw_y         = res_reg.draw_y;
    assign draw_colour    = res_reg.draw_colour;
    assign scroll_request = res_reg.scroll_request;
    assign cursor_col     = res_reg.cursor_col;
    assign cursor_row     = res_reg.cursor_row;

`ifndef SYNTH
    // Cursor state and the loaded result agree
    a_cursor_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (cursor_col == col_reg) && (cursor_row == row_reg))
        else $error("cursor state differs from the result beat");

    // A scroll pins the cursor to column zero
    a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scroll_request) |-> (cursor_col == 6'd0))
        else $error("scroll with a non-zero column");

    // No draw means blank draw fields
    a_no_draw_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !draw_valid) |->
            (draw_glyph == 8'd0) && (draw_x == 10'd0) && (draw_y == 10'd0)
            && (draw_colour == 4'd0))
        else $error("draw fields set without a draw");

    // Newline and return never reach the drawing side
    a_no_ctrl_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && draw_valid) |->
            !((draw_glyph == CODE_NL) || (draw_glyph == CODE_CR)))
        else $error("control code sent as a glyph");
`endif

endmodule
